// ----- sv/igit_pkg.sv -----
package igit_pkg;

	// Table depth and field widths
	localparam int ENTRIES_DEF = 64;
	localparam int GROUP_ID_W  = 7;
	localparam int QUEUE_DEPTH = 2;

	// Result status codes
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	// One input beat: the file identity
	typedef struct packed {
		logic [31:0] device_number;
		logic [63:0] inode_number;
	} in_beat_t;

	// One result beat
	typedef struct packed {
		logic [GROUP_ID_W-1:0] group_id;
		logic                  first_seen;
		logic                  status;
	} out_beat_t;

endpackage

// ----- sv/igit_fifo.sv -----
module igit_fifo import igit_pkg::*; #(
	parameter type beat_t = in_beat_t,
	parameter int  DEPTH  = QUEUE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	output logic  full,
	input  beat_t wdata,
	input  logic  pop,
	output logic  empty,
	output beat_t rdata
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	beat_t           slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   fill_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (fill_q == CW'(DEPTH));
	assign empty   = (fill_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_ptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + CW'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - CW'(1);
			end
		end
	end

	// Beat storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ----- sv/igit_scan.sv -----
module igit_scan import igit_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	// request side (front queue)
	input  logic      req_empty,
	input  in_beat_t  req_data,
	output logic      req_pop,
	// result side (output queue)
	input  logic      res_full,
	output logic      res_push,
	output out_beat_t res_data
);

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int SW = (CW + 1 > GROUP_ID_W) ? CW + 1 : GROUP_ID_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_RESP
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   rd_idx_q;
	logic            chk_vld_s1;
	logic [CW-1:0]   chk_idx_s1;
	in_beat_t        rdata_s1;
	in_beat_t        key_q;
	out_beat_t       res_q;
	in_beat_t        mem [ENTRIES];

	logic            hit;
	logic            miss;
	logic            rd_en;
	logic            wr_en;
	logic            tbl_full;
	logic [SW-1:0]   hit_id;
	logic [SW-1:0]   ins_id;

	// Compare the entry read last cycle against the key
	assign hit      = (state_q == S_SCAN) && chk_vld_s1 && (rdata_s1 == key_q);
	assign miss     = (state_q == S_SCAN) && !hit && (rd_idx_q == count_q);
	assign rd_en    = (state_q == S_SCAN) && !hit && (rd_idx_q != count_q);
	assign tbl_full = (count_q == CW'(ENTRIES));
	assign wr_en    = miss && !tbl_full;
	assign hit_id   = SW'(chk_idx_s1) + SW'(1);
	assign ins_id   = SW'(count_q) + SW'(1);

	assign req_pop  = (state_q == S_IDLE) && !req_empty;
	assign res_push = (state_q == S_RESP);
	assign res_data = res_q;

	// Sequencer: take a key, walk the table, hold the answer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			rd_idx_q   <= '0;
			chk_vld_s1 <= 1'b0;
		end else begin
			chk_vld_s1 <= rd_en;
			case (state_q)
				S_IDLE: begin
					if (!req_empty) begin
						rd_idx_q <= '0;
						state_q  <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (rd_en) begin
						rd_idx_q <= rd_idx_q + CW'(1);
					end
					if (wr_en) begin
						count_q <= count_q + CW'(1);
					end
					if (hit || miss) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (!res_full) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Key, compare index and result payload
	always_ff @(posedge clk) begin
		if (req_pop) begin
			key_q <= req_data;
		end
		if (rd_en) begin
			chk_idx_s1 <= rd_idx_q;
		end
		if (hit) begin
			res_q.group_id   <= hit_id[GROUP_ID_W-1:0];
			res_q.first_seen <= 1'b0;
			res_q.status     <= STATUS_OK;
		end else if (miss && tbl_full) begin
			res_q.group_id   <= '0;
			res_q.first_seen <= 1'b0;
			res_q.status     <= STATUS_FULL;
		end else if (miss) begin
			res_q.group_id   <= ins_id[GROUP_ID_W-1:0];
			res_q.first_seen <= 1'b1;
			res_q.status     <= STATUS_OK;
		end
	end

	// Key table: one read port, append on miss while the table is not full
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[AW-1:0]] <= key_q;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_idx_q[AW-1:0]];
		end
	end

endmodule

// ----- sv/inode_group_id_table_top.sv -----
// File identity to link group id map.
// Input channel: push/full with item (device_number, inode_number). A beat
// is taken on a clock edge with push high and full low; a two-deep queue
// in front lets the source keep pushing while a lookup is in progress.
// Result channel: empty/pop with result (group_id, first_seen, status). The
// oldest result sits on result while empty is low and leaves on pop. A
// two-deep queue decouples the receiver; if it stops popping, the lookup
// engine holds its answer and the front queue fills, then full rises.
// Each item goes through three steps: take the key, read the table through
// its single registered read port and compare each stored entry up to the
// last, then hand the answer over. A hit ends the scan early. The lookup
// engine takes a new key only after it has handed over the answer for the
// previous one, so throughput is set by the scan through that memory port.
// A miss appends the key and returns id = index + 1 with first_seen set; a
// miss on a full table returns status full and group id 0.
// Reset (arst_n low) empties both queues and the table count; the key
// memory itself is not cleared, entries past the count are never read.
module inode_group_id_table_top import igit_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_beat_t  item,
	output logic      empty,
	input  logic      pop,
	output out_beat_t result
);

	logic      req_empty;
	logic      req_pop;
	in_beat_t  req_data;
	logic      res_full;
	logic      res_push;
	out_beat_t res_data;

	// Front: request queue
	igit_fifo #(
		.beat_t (in_beat_t),
		.DEPTH  (QUEUE_DEPTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.wdata  (item),
		.pop    (req_pop),
		.empty  (req_empty),
		.rdata  (req_data)
	);

	// Back: table lookup and insert
	igit_scan #(
		.ENTRIES (ENTRIES)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_empty (req_empty),
		.req_data  (req_data),
		.req_pop   (req_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_data  (res_data)
	);

	// Result queue
	igit_fifo #(
		.beat_t (out_beat_t),
		.DEPTH  (QUEUE_DEPTH)
	) u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.full   (res_full),
		.wdata  (res_data),
		.pop    (pop),
		.empty  (empty),
		.rdata  (result)
	);

endmodule
